// ----- src/lkv_pkg.sv -----
package lkv_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Cells per group in the first level of the hit reduction.
    localparam int GROUP = 16;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CMP,
        CMD_PROMOTE,
        CMD_INSERT,
        CMD_SHIFT
    } cell_cmd_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } cell_ctl_t;

endpackage

// ----- src/lkv_cell.sv -----
module lkv_cell #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
    parameter int IDX     = 0,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lkv_pkg::cell_ctl_t        ctl,
    input  logic [IW-1:0]             hit_idx,
    input  logic [IW-1:0]             slot,
    input  logic                      nb_valid,
    input  logic [lkv_pkg::KEY_W-1:0] nb_key,
    input  logic [lkv_pkg::VAL_W-1:0] nb_value,
    output logic                      valid,
    output logic [lkv_pkg::KEY_W-1:0] key,
    output logic [lkv_pkg::VAL_W-1:0] value,
    output logic                      hit
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                      valid_reg, valid_next;
    logic                      hit_reg, hit_next;
    logic [lkv_pkg::KEY_W-1:0] key_reg, key_next;
    logic [lkv_pkg::VAL_W-1:0] value_reg, value_next;

    always_comb begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        key_next   = key_reg;
        value_next = value_reg;
        case (ctl.cmd)
            lkv_pkg::CMD_CMP: begin
                hit_next = valid_reg && (key_reg == ctl.key);
            end
            lkv_pkg::CMD_PROMOTE: begin
                // The hit entry goes to the most recent slot; the ones above it close the gap.
                if (MY_IDX == slot) begin
                    key_next   = ctl.key;
                    value_next = ctl.value;
                end else if (MY_IDX >= hit_idx && MY_IDX < slot) begin
                    key_next   = nb_key;
                    value_next = nb_value;
                end
            end
            lkv_pkg::CMD_INSERT: begin
                if (MY_IDX == slot) begin
                    valid_next = 1'b1;
                    key_next   = ctl.key;
                    value_next = ctl.value;
                end
            end
            lkv_pkg::CMD_SHIFT: begin
                valid_next = nb_valid;
                key_next   = nb_key;
                value_next = nb_value;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

// ----- src/lkv_reduce.sv -----
module lkv_reduce #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [ENTRIES-1:0]        hit,
    input  logic [lkv_pkg::VAL_W-1:0] cell_value [ENTRIES],
    output logic                      found,
    output logic [lkv_pkg::VAL_W-1:0] found_value,
    output logic [IW-1:0]             found_idx
);

    localparam int NG = (ENTRIES + lkv_pkg::GROUP - 1) / lkv_pkg::GROUP;

    logic                      grp_hit_reg   [NG];
    logic [lkv_pkg::VAL_W-1:0] grp_value_reg [NG];
    logic [IW-1:0]             grp_idx_reg   [NG];
    logic                      grp_hit_next   [NG];
    logic [lkv_pkg::VAL_W-1:0] grp_value_next [NG];
    logic [IW-1:0]             grp_idx_next   [NG];

    // Keys are unique in the store, so at most one cell hits and OR-ing is a select.
    always_comb begin
        int n;
        for (int g = 0; g < NG; g++) begin
            grp_hit_next[g]   = 1'b0;
            grp_value_next[g] = '0;
            grp_idx_next[g]   = '0;
            for (int e = 0; e < lkv_pkg::GROUP; e++) begin
                n = g * lkv_pkg::GROUP + e;
                if (n < ENTRIES) begin
                    if (hit[n]) begin
                        grp_hit_next[g]   = 1'b1;
                        grp_value_next[g] = grp_value_next[g] | cell_value[n];
                        grp_idx_next[g]   = grp_idx_next[g] | IW'(n);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NG; g++) begin
                grp_hit_reg[g] <= 1'b0;
            end
        end else begin
            for (int g = 0; g < NG; g++) begin
                grp_hit_reg[g] <= grp_hit_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NG; g++) begin
            grp_value_reg[g] <= grp_value_next[g];
            grp_idx_reg[g]   <= grp_idx_next[g];
        end
    end

    always_comb begin
        found       = 1'b0;
        found_value = '0;
        found_idx   = '0;
        for (int g = 0; g < NG; g++) begin
            if (grp_hit_reg[g]) begin
                found       = 1'b1;
                found_value = found_value | grp_value_reg[g];
                found_idx   = found_idx | grp_idx_reg[g];
            end
        end
    end

endmodule

// ----- src/lru_key_value_cache.sv -----
// Fully associative key/value cache with least-recently-used replacement, built as a
// chain of ENTRIES cells kept in recency order (cell 0 least recent). A get (tuser 0)
// returns one transfer: tuser is the found flag and tdata the stored value, or all ones
// on a miss; a hit makes the entry most recent. A put (tuser 1) stores or updates an
// entry as most recent and returns nothing. Items are handled one at a time, each in the
// steps broadcast compare in every cell, grouped hit reduction, final select and chain
// update, plus a chain shift for every entry a put of a new key evicts, plus any wait
// for the result register to drain. The store is empty after reset. capacity may be
// written only while no item is in flight; zero acts as one and values above ENTRIES
// act as ENTRIES. Lowering it evicts nothing until the next put of a new key.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [31:0] key, [63:32] value
    input  logic [63:0]               s_axis_tdata,
    // [0] opcode
    input  logic                      s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [31:0] read_value
    output logic [31:0]               m_axis_tdata,
    // [0] found
    output logic                      m_axis_tuser,

    input  logic                      cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > lkv_pkg::CAP_W) ? OW : lkv_pkg::CAP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_GRP  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [OW-1:0]             occ_reg, occ_next;
    logic [lkv_pkg::CAP_W-1:0] cap_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_found_reg, out_found_next;
    logic [lkv_pkg::VAL_W-1:0] out_data_reg, out_data_next;
    logic                      op_reg;
    logic [lkv_pkg::KEY_W-1:0] key_reg;
    logic [lkv_pkg::VAL_W-1:0] val_reg;

    lkv_pkg::cell_ctl_t        ctl;
    logic [IW-1:0]             cell_slot;
    logic [OW-1:0]             occ_last;
    logic [CMPW-1:0]           cap_ext, eff_cap;

    logic [ENTRIES-1:0]        cell_valid;
    logic [ENTRIES-1:0]        cell_hit;
    logic [lkv_pkg::KEY_W-1:0] cell_key   [ENTRIES];
    logic [lkv_pkg::VAL_W-1:0] cell_value [ENTRIES];

    logic                      red_found;
    logic [lkv_pkg::VAL_W-1:0] red_value;
    logic [IW-1:0]             red_idx;

    logic                      in_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign occ_last = occ_reg - OW'(1);
    assign cap_ext  = CMPW'(cap_reg);
    assign eff_cap  = (cap_ext == '0) ? CMPW'(1) :
                      ((cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext);

    always_comb begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_data_next  = out_data_reg;
        ctl.cmd        = lkv_pkg::CMD_NONE;
        ctl.key        = key_reg;
        ctl.value      = val_reg;
        cell_slot      = occ_last[IW-1:0];

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ctl.cmd    = lkv_pkg::CMD_CMP;
                state_next = ST_GRP;
            end
            ST_GRP: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (op_reg == lkv_pkg::OP_GET) begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_next = 1'b1;
                        out_found_next = red_found;
                        out_data_next  = red_found ? red_value : lkv_pkg::MISS_VALUE;
                        if (red_found) begin
                            ctl.cmd   = lkv_pkg::CMD_PROMOTE;
                            ctl.value = red_value;
                        end
                        state_next = ST_IDLE;
                    end
                end else if (red_found) begin
                    ctl.cmd    = lkv_pkg::CMD_PROMOTE;
                    state_next = ST_IDLE;
                end else if (CMPW'(occ_reg) >= eff_cap) begin
                    // Drop the least recent entry and look again next cycle.
                    ctl.cmd  = lkv_pkg::CMD_SHIFT;
                    occ_next = occ_last;
                end else begin
                    ctl.cmd    = lkv_pkg::CMD_INSERT;
                    cell_slot  = occ_reg[IW-1:0];
                    occ_next   = occ_reg + OW'(1);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            cap_reg       <= lkv_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg <= out_found_next;
        out_data_reg  <= out_data_next;
        if (in_xfer) begin
            op_reg  <= s_axis_tuser;
            key_reg <= s_axis_tdata[31:0];
            val_reg <= s_axis_tdata[63:32];
        end
    end

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        logic                      nb_valid;
        logic [lkv_pkg::KEY_W-1:0] nb_key;
        logic [lkv_pkg::VAL_W-1:0] nb_value;

        if (i == ENTRIES - 1) begin : g_top
            assign nb_valid = 1'b0;
            assign nb_key   = '0;
            assign nb_value = '0;
        end else begin : g_mid
            assign nb_valid = cell_valid[i+1];
            assign nb_key   = cell_key[i+1];
            assign nb_value = cell_value[i+1];
        end

        lkv_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .hit_idx  (red_idx),
            .slot     (cell_slot),
            .nb_valid (nb_valid),
            .nb_key   (nb_key),
            .nb_value (nb_value),
            .valid    (cell_valid[i]),
            .key      (cell_key[i]),
            .value    (cell_value[i]),
            .hit      (cell_hit[i])
        );
    end

    lkv_reduce #(
        .ENTRIES (ENTRIES)
    ) u_reduce (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .hit         (cell_hit),
        .cell_value  (cell_value),
        .found       (red_found),
        .found_value (red_value),
        .found_idx   (red_idx)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int       ENTRIES           = lkv_pkg::ENTRIES_DEFAULT;
    localparam int       KEY_W             = lkv_pkg::KEY_W;
    localparam int       VAL_W             = lkv_pkg::VAL_W;
    localparam int       CAP_W             = lkv_pkg::CAP_W;
    localparam logic     OP_GET            = lkv_pkg::OP_GET;
    localparam logic     OP_PUT            = lkv_pkg::OP_PUT;
    localparam logic [lkv_pkg::VAL_W-1:0] MISS_VALUE = lkv_pkg::MISS_VALUE;
    localparam logic [lkv_pkg::CAP_W-1:0] CAP_RESET  = lkv_pkg::CAP_RESET;
    localparam realtime  CLK_PERIOD        = 12.0;
    // Worst case is far below this: every put evicting a full store plus long receiver stalls.
    localparam int       TIMEOUT_CYCLES    = 400_000;
    // Covers a put that evicts every entry after the last read has come back.
    localparam int       DRAIN_CYCLES      = 48;
    localparam int       LONG_STALL_CYCLES = 300;
    localparam int       KEY_POOL_SIZE     = 24;
    localparam int       NUM_PHASES        = 10;
    localparam int       PHASE_ITEMS       = 93;
    localparam int       N_DIRECTED        = 29;

    typedef struct packed {
        logic               found;
        logic [VAL_W-1:0]   value;
    } read_result_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        bit                 typed;
        logic               exp_found;
        logic [VAL_W-1:0]   exp_value;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [63:0]            s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [31:0]            m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_wr_en;
    logic [CAP_W-1:0]       cfg_wr_data;

    // Shadow of the store in recency order: slot 0 least recent.
    logic [KEY_W-1:0]       lru_keys [ENTRIES];
    logic [VAL_W-1:0]       lru_vals [ENTRIES];
    int                     cached;
    logic [CAP_W-1:0]       capacity_reg;

    read_result_t           pending_reads [$];
    int                     check_failures;
    int                     sender_idle_pct;
    int                     receiver_idle_pct;
    bit                     long_stall_req;

    // Directed rows: a typed expectation stands only where it is obvious.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_ITEM, OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_ITEM, OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_ITEM, OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_ITEM, OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_CFG,  OP_PUT, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_CFG,  OP_PUT, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, MISS_VALUE},
        '{ROW_CFG,  OP_PUT, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0003, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0004, 32'h0000_0004, 1'b0, 1'b0, 32'h0},
        '{ROW_CFG,  OP_PUT, 32'h0, 32'd2, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0001, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0003, 32'h0000_0033, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_PUT, 32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0003, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0001, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0005, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, OP_GET, 32'h0000_0004, 32'h0, 1'b0, 1'b0, 32'h0}
    };

    lru_key_value_cache #(
        .ENTRIES        (ENTRIES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int effective_capacity(input logic [CAP_W-1:0] cap);
        if (cap == '0) begin
            return 1;
        end
        if (int'(cap) > ENTRIES) begin
            return ENTRIES;
        end
        return int'(cap);
    endfunction

    task automatic move_to_recent(input int slot);
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        k = lru_keys[slot];
        v = lru_vals[slot];
        for (int i = slot; i < cached - 1; i++) begin
            lru_keys[i] = lru_keys[i + 1];
            lru_vals[i] = lru_vals[i + 1];
        end
        lru_keys[cached - 1] = k;
        lru_vals[cached - 1] = v;
    endtask

    // Applies one accepted item to the shadow store; a get yields a read result.
    task automatic cache_access(input logic op, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v, output bit gives,
                                output read_result_t res);
        int slot;
        int lim;
        slot = -1;
        for (int i = 0; i < cached; i++) begin
            if (slot < 0 && lru_keys[i] == k) begin
                slot = i;
            end
        end
        gives = (op == OP_GET);
        res.found = (slot >= 0);
        res.value = MISS_VALUE;
        if (op == OP_GET) begin
            if (slot >= 0) begin
                res.value = lru_vals[slot];
                move_to_recent(slot);
            end
        end else if (slot >= 0) begin
            lru_vals[slot] = v;
            move_to_recent(slot);
        end else begin
            lim = effective_capacity(capacity_reg);
            // A lowered capacity is enforced here, dropping the oldest entries in turn.
            while (cached >= lim) begin
                for (int i = 0; i < cached - 1; i++) begin
                    lru_keys[i] = lru_keys[i + 1];
                    lru_vals[i] = lru_vals[i + 1];
                end
                cached--;
            end
            lru_keys[cached] = k;
            lru_vals[cached] = v;
            cached++;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v, input bit typed,
                             input read_result_t typed_res);
        bit gives;
        read_result_t res;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {v, k};
        do begin
            @(posedge aclk);
        end while (!s_axis_tready);
        cache_access(op, k, v, gives, res);
        if (gives) begin
            pending_reads.push_back(typed ? typed_res : res);
        end
        @(negedge aclk);
    endtask

    // Capacity is only written once the block has gone quiet.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        s_axis_tvalid = 1'b0;
        while (pending_reads.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = cap;
        capacity_reg = cap;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    always @(posedge aclk) begin
        read_result_t exp;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected result transfer: found %0b, read_value %h",
                       m_axis_tuser, m_axis_tdata);
                check_failures++;
            end else begin
                exp = pending_reads.pop_front();
                if (m_axis_tuser !== exp.found) begin
                    $error("found: expected %0b, got %0b", exp.found, m_axis_tuser);
                    check_failures++;
                end
                if (m_axis_tdata !== exp.value) begin
                    $error("read_value: expected %h, got %h", exp.value, m_axis_tdata);
                    check_failures++;
                end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_axis_tready  = 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge aclk);
            end
            m_axis_tready = ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        stim_row_t row;
        read_result_t typed_res;
        logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
        logic [KEY_W-1:0] edge_keys [4];
        logic [CAP_W-1:0] phase_caps [NUM_PHASES];
        logic [KEY_W-1:0] k;
        logic op;
        int pool_n;
        int roll;

        edge_keys  = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        phase_caps = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd8, 5'd0, 5'd17, 5'd5, 5'd16, 5'd12};
        foreach (key_pool[i]) begin
            key_pool[i] = $urandom;
        end

        aresetn           = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tuser      = OP_GET;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        cached            = 0;
        capacity_reg      = CAP_RESET;
        check_failures    = 0;
        long_stall_req    = 1'b0;
        sender_idle_pct   = 24;
        receiver_idle_pct = 56;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                write_capacity(row.value[CAP_W-1:0]);
            end else begin
                typed_res.found = row.exp_found;
                typed_res.value = row.exp_value;
                send_item(row.op, row.key, row.value, row.typed, typed_res);
            end
        end

        typed_res = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                sender_idle_pct   = 24;
                receiver_idle_pct = 56;
            end else if (p < 6) begin
                sender_idle_pct   = 56;
                receiver_idle_pct = 24;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            write_capacity(phase_caps[p]);
            // Keep the key set a little wider than the store so hits and evictions mix.
            pool_n = effective_capacity(phase_caps[p]) + 4;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 6 && n == 20) begin
                    long_stall_req = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 85) begin
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                end else if (roll < 95) begin
                    k = $urandom;
                end else begin
                    k = edge_keys[$urandom_range(0, 3)];
                end
                op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
                send_item(op, k, $urandom, 1'b0, typed_res);
            end
        end

        s_axis_tvalid = 1'b0;
        while (pending_reads.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (check_failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/lkv_pkg.sv
src/lkv_cell.sv
src/lkv_reduce.sv
src/lru_key_value_cache.sv
dv/testbench.sv
